// ===== hdl/srpm_pkg.sv =====
// Shared types, constants and saturating helpers for the sparse row pattern metrics unit.
package srpm_pkg;

	localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
	localparam logic [16:0] DENS_ONE   = 17'h1_0000;
	localparam int          DENS_STEPS = 16;
	localparam int          MEAN_STEPS = 40;
	localparam int          CNT_W      = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CHECK,
		ST_DENS,
		ST_MEAN,
		ST_EMIT
	} srpm_state_t;

	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (v == SAT32) ? v : v + 32'd1;
	endfunction

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? SAT32 : s[31:0];
	endfunction

endpackage

// ===== hdl/sparse_row_pattern_metrics_unit.sv =====
// Per-row sparsity pattern metrics over a stream of CSR column indices.
//
// Input channel: column_index, last_in_row, empty_row with in_valid / in_stall.
// One beat carries one nonzero's column, ascending within a row; last_in_row
// closes the row. A beat with empty_row set stands for a whole row with no
// nonzeros (any open partial row is dropped without a result).
// Output channel: one beat per finished row with out_valid / out_stall:
// row_number, nonzeros, span, density_q16 (Q1.16), run_count, mean_run_len_q8.
// Input flow: a beat that does not close a row is taken without a stall and the
// next beat may follow at once. A closing beat holds in_stall high through
// the row-end work: the setup and check states, the shared restoring divider
// for the density, then for the mean run length, and the emit state that loads
// the output register. Either division is skipped when its divisor is zero or
// its result saturates. The divider is a single step (33-bit compare and subtract).
// The result sits in an output register; further non-closing beats are taken
// while it waits. If the receiver stalls, the next closing row waits in the
// emit state until the output register is free, stalling the input.
// Reset (arst_n low) clears the row counter and the open-row state and empties
// the output register.
module sparse_row_pattern_metrics_unit
	import srpm_pkg::*;
#(
	parameter int INDEX_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] column_index,
	input  logic        last_in_row,
	input  logic        empty_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] row_number,
	output logic [31:0] nonzeros,
	output logic [31:0] span,
	output logic [16:0] density_q16,
	output logic [31:0] run_count,
	output logic [39:0] mean_run_len_q8
);

	srpm_state_t state_q, state_d;

	// open-row state
	logic [31:0] row_counter_q;
	logic [31:0] nnz_q;
	logic        inside_q;
	logic [31:0] cur_q;
	logic [31:0] runs_q;
	logic [31:0] total_q;
	logic [INDEX_WIDTH-1:0] first_q;
	logic [INDEX_WIDTH-1:0] prev_q;

	// snapshot of a closed row
	logic [31:0] snap_row_q;
	logic        snap_empty_q;
	logic [31:0] snap_nnz_q;
	logic [31:0] snap_runs_q;
	logic [31:0] snap_total_q;
	logic [INDEX_WIDTH-1:0] snap_first_q;
	logic [INDEX_WIDTH-1:0] snap_last_q;
	logic [31:0] span_q;
	logic [16:0] dens_q;
	logic [39:0] mean_q;

	// shared divider
	logic [31:0]      div_rem_q;
	logic [39:0]      div_dvd_q;
	logic [CNT_W-1:0] div_cnt_q;

	// output register
	logic        out_valid_q;
	logic [31:0] row_number_q;
	logic [31:0] nonzeros_q;
	logic [31:0] span_out_q;
	logic [16:0] density_q;
	logic [31:0] run_count_q;
	logic [39:0] mean_out_q;

	logic accept;
	logic closes_row;
	logic load_out;
	logic go_dens;
	logic div_last;

	// per-beat update
	logic [INDEX_WIDTH-1:0] col_w;
	logic [INDEX_WIDTH:0]   prev_inc;
	logic                   nnz_zero;
	logic                   consec;
	logic [INDEX_WIDTH-1:0] first_mid;
	logic                   inside_mid;
	logic [31:0]            cur_mid;
	logic [31:0]            runs_mid;
	logic [31:0]            total_mid;
	logic [31:0]            nnz_nx;
	logic [31:0]            runs_fin;
	logic [31:0]            total_fin;

	// span
	logic [INDEX_WIDTH:0] span_diff;
	logic [32:0]          span_wide;
	logic [31:0]          span_sat;

	// divider step
	logic [31:0] divisor;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        quo_bit;
	logic [31:0] rem_nx;
	logic [39:0] dvd_nx;

	assign accept     = in_valid && !in_stall;
	assign closes_row = last_in_row || empty_row;

	assign col_w    = column_index[INDEX_WIDTH-1:0];
	assign nnz_zero = (nnz_q == 32'd0);
	assign prev_inc = {1'b0, prev_q} + {{INDEX_WIDTH{1'b0}}, 1'b1};
	assign consec   = (prev_inc == {1'b0, col_w});
	assign nnz_nx   = sat_inc32(nnz_q);

	always_comb begin
		first_mid  = first_q;
		inside_mid = inside_q;
		cur_mid    = cur_q;
		runs_mid   = runs_q;
		total_mid  = total_q;
		if (nnz_zero) begin
			first_mid  = col_w;
			inside_mid = 1'b0;
			cur_mid    = 32'd1;
			runs_mid   = 32'd0;
			total_mid  = 32'd0;
		end else if (consec) begin
			inside_mid = 1'b1;
			cur_mid    = sat_inc32(cur_q);
		end else if (inside_q) begin
			// a gap closes the run in progress
			runs_mid   = sat_inc32(runs_q);
			total_mid  = sat_add32(total_q, cur_q);
			inside_mid = 1'b0;
			cur_mid    = 32'd1;
		end
		// a run still open at the row's end is closed too
		runs_fin  = inside_mid ? sat_inc32(runs_mid) : runs_mid;
		total_fin = inside_mid ? sat_add32(total_mid, cur_mid) : total_mid;
	end

	assign span_diff = {1'b0, snap_last_q} - {1'b0, snap_first_q}
		+ {{INDEX_WIDTH{1'b0}}, 1'b1};
	assign span_wide = 33'(span_diff);
	assign span_sat  = span_wide[32] ? SAT32 : span_wide[31:0];

	// one restoring division step, shared by density and mean
	assign divisor = (state_q == ST_DENS) ? span_q : snap_runs_q;
	assign rem_sh  = {div_rem_q, div_dvd_q[39]};
	assign rem_sub = rem_sh - {1'b0, divisor};
	assign quo_bit = (rem_sh >= {1'b0, divisor});
	assign rem_nx  = quo_bit ? rem_sub[31:0] : rem_sh[31:0];
	assign dvd_nx  = {div_dvd_q[38:0], quo_bit};
	assign div_last = (div_cnt_q == CNT_W'(1));

	// density below one only when nonzeros < span; otherwise saturated or zero
	assign go_dens = (span_q != 32'd0) && (snap_nnz_q < span_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && closes_row) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (go_dens) begin
					state_d = ST_DENS;
				end else if (snap_runs_q != 32'd0) begin
					state_d = ST_MEAN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DENS: begin
				if (div_last) begin
					state_d = (snap_runs_q != 32'd0) ? ST_MEAN : ST_EMIT;
				end
			end
			ST_MEAN: begin
				if (div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// open-row control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_counter_q <= 32'd0;
			nnz_q         <= 32'd0;
			inside_q      <= 1'b0;
			cur_q         <= 32'd1;
			runs_q        <= 32'd0;
			total_q       <= 32'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (closes_row) begin
					row_counter_q <= row_counter_q + 32'd1;
					nnz_q         <= 32'd0;
					inside_q      <= 1'b0;
					cur_q         <= 32'd1;
					runs_q        <= 32'd0;
					total_q       <= 32'd0;
				end else begin
					nnz_q    <= nnz_nx;
					inside_q <= inside_mid;
					cur_q    <= cur_mid;
					runs_q   <= runs_mid;
					total_q  <= total_mid;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// column tracking and row snapshot
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!empty_row) begin
				prev_q <= col_w;
				if (nnz_zero) begin
					first_q <= col_w;
				end
			end
			if (closes_row) begin
				snap_row_q   <= row_counter_q;
				snap_empty_q <= empty_row;
				snap_nnz_q   <= empty_row ? 32'd0 : nnz_nx;
				snap_runs_q  <= empty_row ? 32'd0 : runs_fin;
				snap_total_q <= empty_row ? 32'd0 : total_fin;
				snap_first_q <= first_mid;
				snap_last_q  <= col_w;
			end
		end
	end

	// span, divider sequencing and quotients
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SETUP: begin
				if (snap_empty_q || (snap_last_q < snap_first_q)) begin
					span_q <= 32'd0;
				end else begin
					span_q <= span_sat;
				end
			end
			ST_CHECK: begin
				dens_q <= (span_q == 32'd0) ? 17'd0 : DENS_ONE;
				mean_q <= 40'd0;
				if (go_dens) begin
					div_rem_q <= snap_nnz_q;
					div_dvd_q <= 40'd0;
					div_cnt_q <= CNT_W'(DENS_STEPS);
				end else begin
					div_rem_q <= 32'd0;
					div_dvd_q <= {snap_total_q, 8'd0};
					div_cnt_q <= CNT_W'(MEAN_STEPS);
				end
			end
			ST_DENS: begin
				if (div_last) begin
					dens_q    <= {1'b0, dvd_nx[15:0]};
					div_rem_q <= 32'd0;
					div_dvd_q <= {snap_total_q, 8'd0};
					div_cnt_q <= CNT_W'(MEAN_STEPS);
				end else begin
					div_rem_q <= rem_nx;
					div_dvd_q <= dvd_nx;
					div_cnt_q <= div_cnt_q - CNT_W'(1);
				end
			end
			ST_MEAN: begin
				div_rem_q <= rem_nx;
				div_dvd_q <= dvd_nx;
				div_cnt_q <= div_cnt_q - CNT_W'(1);
				if (div_last) begin
					mean_q <= dvd_nx;
				end
			end
			default: begin
			end
		endcase
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			row_number_q <= snap_row_q;
			nonzeros_q   <= snap_nnz_q;
			span_out_q   <= span_q;
			density_q    <= dens_q;
			run_count_q  <= snap_runs_q;
			mean_out_q   <= mean_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign row_number      = row_number_q;
	assign nonzeros        = nonzeros_q;
	assign span            = span_out_q;
	assign density_q16     = density_q;
	assign run_count       = run_count_q;
	assign mean_run_len_q8 = mean_out_q;

endmodule

// ===== hdl/srpm_checker.sv =====
// Port-level assertions for the sparse row pattern metrics unit, with its bind.
module srpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_in_row,
	input logic        empty_row,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] row_number,
	input logic [31:0] nonzeros,
	input logic [31:0] span,
	input logic [16:0] density_q16,
	input logic [31:0] run_count,
	input logic [39:0] mean_run_len_q8
);

	// a closing beat starts the row-end work, so the input stalls next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (last_in_row || empty_row) |=> in_stall)
	else $error("closing beat did not stall the input");

	// a mid-row beat does not stall the input
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_in_row && !empty_row |=> !in_stall)
	else $error("mid-row beat stalled the input");

	// density never exceeds one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> density_q16 <= 17'h1_0000)
	else $error("density above one");

	// only an empty row reports no nonzeros, and then every metric is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nonzeros == 32'd0 |->
			span == 32'd0 && density_q16 == 17'd0 && run_count == 32'd0
			&& mean_run_len_q8 == 40'd0)
	else $error("empty row with non-zero metrics");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_number) && $stable(nonzeros)
			&& $stable(mean_run_len_q8))
	else $error("stalled result changed");

endmodule

bind sparse_row_pattern_metrics_unit srpm_checker u_srpm_checker (.*);
